@@ hdl/mssd_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor speed display package
// Types, codes and segment patterns that the display modules share.
// ----------------------------------------------------------------------------
package mssd_pkg;

   localparam int DIGIT_COUNT = 3;
   localparam int VALUE_W     = 10;
   localparam int BCD_W       = 4 * DIGIT_COUNT;
   localparam int DIVIDEND_W  = 32;
   localparam int DIVISOR_W   = 16;
   localparam int SEG_W       = 7;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd999;
   localparam logic [15:0]        RATED_SPEED_RESET = 16'd3000;
   localparam logic [15:0]        PERCENT_SCALE = 16'd100;

   localparam logic [SEG_W-1:0] PAT_BLANK = 7'h00;
   localparam logic [SEG_W-1:0] PAT_DASH  = 7'h40;

   typedef enum logic [1:0] {
      CSR_RATED_SPEED       = 2'd0,
      CSR_MODE_CYCLE_PERIOD = 2'd1,
      CSR_ANODE_COMMON      = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_RPM     = 2'd0,
      MODE_PERCENT = 2'd1,
      MODE_RAW     = 2'd2
   } display_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MULT,
      ST_DIV,
      ST_BCD,
      ST_OUT
   } seq_state_type;

   function automatic display_mode_type mode_step(input display_mode_type mode);
      display_mode_type result;
      case (mode)
         MODE_RPM:     result = MODE_PERCENT;
         MODE_PERCENT: result = MODE_RAW;
         MODE_RAW:     result = MODE_RPM;
         default:      result = MODE_RPM;
      endcase
      return result;
   endfunction

   function automatic logic [SEG_W-1:0] glyph(input logic [3:0] digit);
      logic [SEG_W-1:0] pattern;
      case (digit)
         4'd0:    pattern = 7'h3F;
         4'd1:    pattern = 7'h06;
         4'd2:    pattern = 7'h5B;
         4'd3:    pattern = 7'h4F;
         4'd4:    pattern = 7'h66;
         4'd5:    pattern = 7'h6D;
         4'd6:    pattern = 7'h7D;
         4'd7:    pattern = 7'h07;
         4'd8:    pattern = 7'h7F;
         4'd9:    pattern = 7'h6F;
         default: pattern = PAT_BLANK;
      endcase
      return pattern;
   endfunction

endpackage

@@ hdl/mssd_divider.sv @@
// ----------------------------------------------------------------------------
// Motor speed display divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mssd_divider
   import mssd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEPS = DIVIDEND_W;
   localparam int CNT_W = $clog2(STEPS);

   logic [DIVIDEND_W-1:0] shift_ff, shift_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   always_comb begin
      trial      = {rem_ff[DIVISOR_W-1:0], shift_ff[DIVIDEND_W-1]};
      fits       = (trial >= {1'b0, divisor_ff});
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      run_in     = run_ff;
      done_in    = 1'b0;
      if (start) begin
         shift_in   = dividend;
         divisor_in = divisor;
         rem_in     = '0;
         cnt_in     = '0;
         run_in     = 1'b1;
      end else if (run_ff) begin
         rem_in   = fits ? (trial - {1'b0, divisor_ff}) : trial;
         shift_in = {shift_ff[DIVIDEND_W-2:0], fits};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

@@ hdl/mssd_bcd.sv @@
// ----------------------------------------------------------------------------
// Motor speed display decimal converter
// Shift-and-add-three conversion of a value up to 999, one bit per cycle.
// ----------------------------------------------------------------------------
module mssd_bcd
   import mssd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] value,
   output logic               done,
   output logic [BCD_W-1:0]   digits
);

   localparam int STEPS = VALUE_W;
   localparam int CNT_W = $clog2(STEPS);

   logic [BCD_W+VALUE_W-1:0] shift_ff, shift_in;
   logic [BCD_W+VALUE_W-1:0] adjusted;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     run_ff, run_in;
   logic                     done_ff, done_in;

   always_comb begin
      adjusted = shift_ff;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (shift_ff[VALUE_W + 4*i +: 4] >= 4'd5) begin
            adjusted[VALUE_W + 4*i +: 4] = shift_ff[VALUE_W + 4*i +: 4] + 4'd3;
         end
      end
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = {{BCD_W{1'b0}}, value};
         cnt_in   = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = {adjusted[BCD_W+VALUE_W-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
   end

   assign done   = done_ff;
   assign digits = shift_ff[BCD_W+VALUE_W-1:VALUE_W];

endmodule

@@ hdl/motor_speed_seven_segment_display.sv @@
// ----------------------------------------------------------------------------
// Motor speed seven-segment display
// Three-digit multiplexed readout of motor speed, percent or raw duty.
// ----------------------------------------------------------------------------
// Each transaction on the request side is one millisecond tick and yields one
// transaction on the response side with the scanned digit's segment and select
// levels. A tick without refresh goes straight to the output state, and a
// refresh while stopped goes there once it has set the blink pattern. A raw-duty
// refresh, an RPM refresh with a zero operand and a percent refresh with a zero
// full duty go through the 10-step decimal conversion only. Any other RPM or
// percent refresh goes through a single 16x16 multiply, the 32-step shared
// divider and then the decimal conversion. An RPM value above 999 skips the
// conversion and shows dashes. A response side that holds off a previous
// transaction stalls each of these in the output state.
module motor_speed_seven_segment_display
   import mssd_pkg::*;
#(
   parameter int BLINK_HALF_PERIOD = 600
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // duty_now[15:0], duty_full[31:16]
   input  logic [2:0]  req_tuser,  // refresh[0], advance_mode[1], motor_stopped[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // segment_lines[6:0], digit_lines[9:7],
                                   // shown_mode[11:10], zero[15:12]
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   seq_state_type    state_ff, state_in;
   logic [31:0]      ms_ff, ms_in;
   logic [31:0]      last_mode_ff, last_mode_in;
   logic [31:0]      last_blink_ff, last_blink_in;
   logic             blink_ff, blink_in;
   display_mode_type mode_ff, mode_in;
   logic [SEG_W-1:0] pat_ff [DIGIT_COUNT];
   logic [SEG_W-1:0] pat_in [DIGIT_COUNT];
   logic [1:0]       scan_ff, scan_in;
   logic             stopped_ff, stopped_in;
   logic [15:0]      duty_ff, duty_in;
   logic [15:0]      full_ff, full_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_data_ff, rsp_data_in;
   logic [15:0]      rated_ff;
   logic [15:0]      period_ff;
   logic             anode_ff;

   logic                  div_start;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] product;
   logic [DIVIDEND_W-1:0] quotient;
   logic                  bcd_start;
   logic [VALUE_W-1:0]    bcd_value;
   logic                  bcd_done;
   logic [BCD_W-1:0]      digits;

   logic [31:0]      mode_elapsed;
   logic [31:0]      blink_elapsed;
   display_mode_type mode_c;
   logic             blink_c;
   logic [SEG_W-1:0] seg_raw;
   logic [SEG_W-1:0] seg_out;
   logic [2:0]       sel_out;

   mssd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (full_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   mssd_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .value  (bcd_value),
      .done   (bcd_done),
      .digits (digits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rated_ff  <= RATED_SPEED_RESET;
         period_ff <= '0;
         anode_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_RATED_SPEED:       rated_ff  <= csr_wdata;
            CSR_MODE_CYCLE_PERIOD: period_ff <= csr_wdata;
            CSR_ANODE_COMMON:      anode_ff  <= csr_wdata[0];
            default:               ;
         endcase
      end
   end

   assign product = 32'(duty_ff) * 32'((mode_ff == MODE_RPM) ? rated_ff : PERCENT_SCALE);

   always_comb begin
      state_in      = state_ff;
      ms_in         = ms_ff;
      last_mode_in  = last_mode_ff;
      last_blink_in = last_blink_ff;
      blink_in      = blink_ff;
      mode_in       = mode_ff;
      pat_in        = pat_ff;
      scan_in       = scan_ff;
      stopped_in    = stopped_ff;
      duty_in       = duty_ff;
      full_in       = full_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      req_tready    = 1'b0;
      div_start     = 1'b0;
      bcd_start     = 1'b0;
      bcd_value     = '0;

      mode_elapsed  = ms_ff - last_mode_ff;
      blink_elapsed = ms_ff - last_blink_ff;
      mode_c        = mode_ff;
      blink_c       = blink_ff;

      seg_raw = pat_ff[scan_ff];
      seg_out = anode_ff ? ~seg_raw : seg_raw;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         sel_out[i] = anode_ff ? (scan_ff == 2'(i)) : (scan_ff != 2'(i));
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ms_in      = ms_ff + 32'd1;
               stopped_in = req_tuser[2];
               duty_in    = req_tdata[15:0];
               full_in    = req_tdata[31:16];
               if (req_tuser[1]) begin
                  mode_in = mode_step(mode_ff);
               end
               state_in = req_tuser[0] ? ST_CHECK : ST_OUT;
            end
         end
         ST_CHECK: begin
            if (period_ff != 16'd0 && mode_elapsed >= {16'd0, period_ff}) begin
               last_mode_in = ms_ff;
               mode_c       = mode_step(mode_ff);
            end
            mode_in = mode_c;
            if (stopped_ff) begin
               if (blink_elapsed >= 32'(BLINK_HALF_PERIOD)) begin
                  last_blink_in = ms_ff;
                  blink_c       = ~blink_ff;
               end
               blink_in  = blink_c;
               pat_in[0] = PAT_BLANK;
               pat_in[1] = PAT_BLANK;
               pat_in[2] = blink_c ? glyph(4'd0) : PAT_BLANK;
               state_in  = ST_OUT;
            end else begin
               case (mode_c)
                  MODE_RAW: begin
                     bcd_start = 1'b1;
                     bcd_value = (duty_ff > 16'(VALUE_MAX)) ? VALUE_MAX : duty_ff[VALUE_W-1:0];
                     state_in  = ST_BCD;
                  end
                  MODE_RPM: begin
                     if (full_ff == 16'd0 || duty_ff == 16'd0) begin
                        bcd_start = 1'b1;
                        state_in  = ST_BCD;
                     end else begin
                        state_in = ST_MULT;
                     end
                  end
                  default: begin
                     if (full_ff == 16'd0) begin
                        bcd_start = 1'b1;
                        state_in  = ST_BCD;
                     end else begin
                        state_in = ST_MULT;
                     end
                  end
               endcase
            end
         end
         ST_MULT: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               if (quotient > 32'(VALUE_MAX)) begin
                  if (mode_ff == MODE_RPM) begin
                     for (int i = 0; i < DIGIT_COUNT; i++) begin
                        pat_in[i] = PAT_DASH;
                     end
                     state_in = ST_OUT;
                  end else begin
                     bcd_start = 1'b1;
                     bcd_value = VALUE_MAX;
                     state_in  = ST_BCD;
                  end
               end else begin
                  bcd_start = 1'b1;
                  bcd_value = quotient[VALUE_W-1:0];
                  state_in  = ST_BCD;
               end
            end
         end
         ST_BCD: begin
            if (bcd_done) begin
               pat_in[0] = (digits[11:8] != 4'd0) ? glyph(digits[11:8]) : PAT_BLANK;
               pat_in[1] = (digits[11:4] != 8'd0) ? glyph(digits[7:4]) : PAT_BLANK;
               pat_in[2] = glyph(digits[3:0]);
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, mode_ff, sel_out, seg_out};
               scan_in      = (scan_ff == 2'(DIGIT_COUNT - 1)) ? 2'd0 : scan_ff + 2'd1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ms_ff         <= '0;
         last_mode_ff  <= '0;
         last_blink_ff <= '0;
         blink_ff      <= 1'b0;
         mode_ff       <= MODE_RPM;
         scan_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            pat_ff[i] <= PAT_BLANK;
         end
      end else begin
         state_ff      <= state_in;
         ms_ff         <= ms_in;
         last_mode_ff  <= last_mode_in;
         last_blink_ff <= last_blink_in;
         blink_ff      <= blink_in;
         mode_ff       <= mode_in;
         scan_ff       <= scan_in;
         rsp_valid_ff  <= rsp_valid_in;
         pat_ff        <= pat_in;
      end
      stopped_ff  <= stopped_in;
      duty_ff     <= duty_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ sim/tb_motor_speed_seven_segment_display.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed display testbench
// Sends millisecond ticks through the request stream and checks every scan
// result against a local model of the display: RPM, percent and raw readouts,
// the blinking zero while stopped, automatic mode cycling and both polarities.
// A short table of directed ticks runs first, then randomized phases with
// different register settings and different amounts of idling on both sides.
// ----------------------------------------------------------------------------
module tb_motor_speed_seven_segment_display
   import mssd_pkg::*;
();

   localparam int BLINK_HALF      = 600;
   localparam int PHASE_COUNT     = 8;
   localparam int TICKS_PER_PHASE = 125;
   localparam int DIRECTED_COUNT  = 22;
   localparam int HOLD_CYCLES     = 400;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 60;
   localparam int CYCLE_LIMIT     = 600000;

   localparam logic [6:0] DIGIT_GLYPH [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   typedef struct packed {
      logic        refresh;
      logic        advance;
      logic        stopped;
      logic [15:0] duty_now;
      logic [15:0] duty_full;
      logic        typed;
      logic [6:0]  seg;
      logic [2:0]  dig;
      logic [1:0]  mode;
   } tick_row_type;

   typedef struct packed {
      logic [6:0] seg;
      logic [2:0] dig;
      logic [1:0] mode;
   } scan_result_type;

   // Directed ticks with the reset settings: rated 3000, no cycling, common cathode.
   localparam tick_row_type DIRECTED [DIRECTED_COUNT] = '{
      '{1'b0, 1'b0, 1'b0, 16'd0,     16'd0,     1'b1, 7'h00, 3'b110, MODE_RPM},
      '{1'b0, 1'b0, 1'b0, 16'd65535, 16'd65535, 1'b1, 7'h00, 3'b101, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd0,     16'd100,   1'b1, 7'h3F, 3'b011, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd65535, 16'd0,     1'b1, 7'h00, 3'b110, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd65535, 16'd1,     1'b1, 7'h40, 3'b101, MODE_RPM},
      '{1'b0, 1'b0, 1'b0, 16'd0,     16'd0,     1'b1, 7'h40, 3'b011, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd999,   16'd3000,  1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd1000,  16'd3000,  1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd1,     16'd65535, 1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b1, 1'b1, 1'b0, 16'd65535, 16'd1,     1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd65535, 16'd0,     1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd50,    16'd100,   1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd65535, 16'd65535, 1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b0, 1'b1, 1'b0, 16'd123,   16'd0,     1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd65535, 16'd0,     1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd7,     16'd0,     1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd0,     16'd65535, 1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b1, 1'b0, 1'b1, 16'd555,   16'd1000,  1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b0, 1'b0, 1'b1, 16'd0,     16'd0,     1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b1, 1'b1, 1'b1, 16'd42,    16'd42,    1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd333,   16'd1000,  1'b0, 7'h00, 3'b000, MODE_RPM},
      '{1'b1, 1'b0, 1'b0, 16'd0,     16'd0,     1'b0, 7'h00, 3'b000, MODE_RPM}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = CSR_RATED_SPEED;
   logic [15:0] csr_wdata = '0;

   // Local copy of the display state and its settings.
   logic [15:0]      cfg_rated = RATED_SPEED_RESET;
   logic [15:0]      cfg_period = '0;
   logic             cfg_anode = 1'b0;
   logic [31:0]      ms_count = '0;
   logic [31:0]      mode_changed_at = '0;
   logic [31:0]      blink_changed_at = '0;
   logic             blink_on = 1'b0;
   display_mode_type mode_now = MODE_RPM;
   logic [6:0]       digit_pattern [DIGIT_COUNT] = '{default: PAT_BLANK};
   int unsigned      scan_pos = 0;

   scan_result_type expected_scans [$];
   scan_result_type got_scan;
   scan_result_type want_scan;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int ticks_sent = 0;
   int scans_checked = 0;
   int error_count = 0;
   int cycle_count = 0;

   motor_speed_seven_segment_display #(
      .BLINK_HALF_PERIOD(BLINK_HALF)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic display_mode_type next_mode(input display_mode_type m);
      display_mode_type n;
      case (m)
         MODE_RPM:     n = MODE_PERCENT;
         MODE_PERCENT: n = MODE_RAW;
         default:      n = MODE_RPM;
      endcase
      return n;
   endfunction

   task automatic load_number(input logic [31:0] value);
      logic [31:0] v;
      v = (value > 32'd999) ? 32'd999 : value;
      digit_pattern[0] = (v >= 100) ? DIGIT_GLYPH[(v / 100) % 10] : PAT_BLANK;
      digit_pattern[1] = (v >= 10) ? DIGIT_GLYPH[(v / 10) % 10] : PAT_BLANK;
      digit_pattern[2] = DIGIT_GLYPH[v % 10];
   endtask

   task automatic step_display(input tick_row_type t, output scan_result_type r);
      logic [63:0] product;
      logic [31:0] value;
      logic [6:0]  seg;
      logic [2:0]  sel;
      ms_count = ms_count + 32'd1;
      if (t.advance)
         mode_now = next_mode(mode_now);
      if (t.refresh) begin
         if (cfg_period != 16'd0 && (ms_count - mode_changed_at) >= {16'd0, cfg_period}) begin
            mode_changed_at = ms_count;
            mode_now = next_mode(mode_now);
         end
         if (t.stopped) begin
            if ((ms_count - blink_changed_at) >= BLINK_HALF) begin
               blink_changed_at = ms_count;
               blink_on = !blink_on;
            end
            if (blink_on)
               load_number(32'd0);
            else
               digit_pattern = '{default: PAT_BLANK};
         end else begin
            case (mode_now)
               MODE_RPM: begin
                  value = 32'd0;
                  if (t.duty_full != 16'd0 && t.duty_now != 16'd0) begin
                     product = 64'(t.duty_now) * 64'(cfg_rated);
                     value = 32'(product / 64'(t.duty_full));
                  end
                  if (value > 32'd999)
                     digit_pattern = '{default: PAT_DASH};
                  else
                     load_number(value);
               end
               MODE_PERCENT: begin
                  value = (t.duty_full != 16'd0) ?
                          (32'(t.duty_now) * 32'd100) / 32'(t.duty_full) : 32'd0;
                  load_number(value);
               end
               default: load_number(32'(t.duty_now));
            endcase
         end
      end
      seg = digit_pattern[scan_pos];
      if (cfg_anode)
         seg = ~seg;
      sel = '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (cfg_anode ? (i == scan_pos) : (i != scan_pos))
            sel[i] = 1'b1;
      end
      scan_pos = (scan_pos + 1) % DIGIT_COUNT;
      r.seg = seg;
      r.dig = sel;
      r.mode = mode_now;
   endtask

   function automatic tick_row_type random_tick(input int stop_pct);
      tick_row_type t;
      t = '0;
      t.refresh = ($urandom_range(99) < 75);
      t.advance = ($urandom_range(99) < 8);
      t.stopped = ($urandom_range(99) < stop_pct);
      case ($urandom_range(4))
         0: begin
            t.duty_now = 16'($urandom);
            t.duty_full = 16'($urandom);
         end
         1: begin
            t.duty_full = 16'($urandom);
            t.duty_now = 16'($urandom_range(t.duty_full));
         end
         2: begin
            t.duty_now = ($urandom_range(2) == 0) ? 16'd0 : ($urandom_range(1) ? 16'd1 : 16'hFFFF);
            t.duty_full = ($urandom_range(2) == 0) ? 16'd0 : ($urandom_range(1) ? 16'd1 : 16'hFFFF);
         end
         3: begin
            t.duty_now = 16'($urandom_range(1200));
            t.duty_full = 16'($urandom_range(1, 1200));
         end
         default: begin
            t.duty_now = 16'($urandom_range(300, 360));
            t.duty_full = 16'd1000;
         end
      endcase
      return t;
   endfunction

   // Offers one tick and waits for its transaction; the valid stays high afterwards.
   task automatic send_tick(input tick_row_type t);
      scan_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {t.duty_full, t.duty_now};
      req_tuser <= {t.stopped, t.advance, t.refresh};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      step_display(t, predicted);
      if (t.typed)
         expected_scans.push_back({t.seg, t.dig, t.mode});
      else
         expected_scans.push_back(predicted);
      ticks_sent++;
   endtask

   task automatic wait_drained(input int extra);
      while (expected_scans.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] rated, input logic [15:0] period,
                                 input logic anode);
      csr_we <= 1'b1;
      csr_addr <= CSR_RATED_SPEED;
      csr_wdata <= rated;
      @(posedge clock);
      cfg_rated = rated;
      csr_addr <= CSR_MODE_CYCLE_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      cfg_period = period;
      csr_addr <= CSR_ANODE_COMMON;
      csr_wdata <= {15'd0, anode};
      @(posedge clock);
      cfg_anode = anode;
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_scan.seg = rsp_tdata[6:0];
         got_scan.dig = rsp_tdata[9:7];
         got_scan.mode = rsp_tdata[11:10];
         if (expected_scans.size() == 0) begin
            $error("unexpected scan result %h", rsp_tdata);
            error_count++;
         end else begin
            want_scan = expected_scans.pop_front();
            scans_checked++;
            if (got_scan.seg !== want_scan.seg) begin
               $error("segment_lines: expected %h, actual %h", want_scan.seg, got_scan.seg);
               error_count++;
            end
            if (got_scan.dig !== want_scan.dig) begin
               $error("digit_lines: expected %b, actual %b", want_scan.dig, got_scan.dig);
               error_count++;
            end
            if (got_scan.mode !== want_scan.mode) begin
               $error("shown_mode: expected %0d, actual %0d", want_scan.mode, got_scan.mode);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [15:0] rated;
      logic [15:0] period;
      logic        anode;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_tick(DIRECTED[i]);
      req_tvalid <= 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained(SETTLE_CYCLES);
         case (phase)
            0: begin rated = 16'd3000;  period = 16'd0;     anode = 1'b1; end
            1: begin rated = 16'd0;     period = 16'd1;     anode = 1'b0; end
            2: begin rated = 16'hFFFF;  period = 16'hFFFF;  anode = 1'b1; end
            3: begin rated = 16'd1;     period = 16'd7;     anode = 1'b0; end
            4: begin
               rated = 16'($urandom);
               period = 16'($urandom_range(1, 100));
               anode = 1'b1;
            end
            5: begin rated = 16'd3000;  period = 16'd0;     anode = 1'b1; end
            6: begin rated = 16'($urandom); period = 16'd2; anode = 1'b0; end
            default: begin rated = 16'hFFFF; period = 16'($urandom); anode = 1'b1; end
         endcase
         apply_settings(rated, period, anode);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         // The receiver holds off for a long stretch while ticks keep coming.
         if (phase == 2)
            hold_requests = hold_requests + 1;
         for (int n = 0; n < TICKS_PER_PHASE; n++)
            send_tick(random_tick((phase == 5) ? 80 : 20));
         req_tvalid <= 1'b0;
      end

      wait_drained(DRAIN_CYCLES);
      $display("Sent %0d ticks in %0d directed rows and %0d setting phases; %0d scans checked.",
               ticks_sent, DIRECTED_COUNT, PHASE_COUNT, scans_checked);
      $display("Covered all three modes, stopped blinking, mode cycling and both polarities.");
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
